// ===== hdl/led_pkg.sv =====
// shared types and constants for the levenshtein edit distance block
package led_pkg;

	localparam int MAX_LEN     = 32;
	localparam int SYMBOL_BITS = 8;
	localparam int LEN_W       = $clog2(MAX_LEN + 1);
	localparam int DIST_W      = 6;

	typedef struct packed {
		logic       command;
		logic       has_symbol;
		logic [7:0] symbol;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} out_word_t;

	// wavefront token handed from cell to cell
	typedef struct packed {
		logic                   valid;
		logic                   compute;
		logic [SYMBOL_BITS-1:0] sym;
		logic [LEN_W-1:0]       left;
		logic [LEN_W-1:0]       diag;
		logic                   fin;
		logic [LEN_W-1:0]       cnt;
		logic                   done;
		logic [LEN_W-1:0]       edit_dist;
		logic                   ovf;
	} tok_t;

	// first-word symbol write
	typedef struct packed {
		logic                   en;
		logic [LEN_W-1:0]       pos;
		logic [SYMBOL_BITS-1:0] sym;
	} wr_t;

endpackage

// ===== hdl/led_in_if.sv =====
// input word channel
interface led_in_if;
	logic               valid;
	logic               ready;
	led_pkg::in_word_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/led_out_if.sv =====
// result word channel
interface led_out_if;
	logic               valid;
	logic               ready;
	led_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/led_cell.sv =====
// one cell of the chain: a first-word symbol and its column of the dp row
module led_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [led_pkg::LEN_W-1:0] pos,
	input  led_pkg::wr_t             wr,
	input  led_pkg::tok_t            tok_in,
	output led_pkg::tok_t            tok_out
);

	logic [led_pkg::SYMBOL_BITS-1:0] sym_q;
	logic [led_pkg::LEN_W-1:0]       dp_q;
	logic [led_pkg::LEN_W-1:0]       min_ld;
	logic [led_pkg::LEN_W-1:0]       min_all;
	logic [led_pkg::LEN_W-1:0]       next;
	led_pkg::tok_t                   tok_d;
	led_pkg::tok_t                   tok_q;

	always_comb begin
		min_ld  = (tok_in.left < tok_in.diag) ? tok_in.left : tok_in.diag;
		min_all = (dp_q < min_ld) ? dp_q : min_ld;
		if (tok_in.valid && tok_in.compute) begin
			if (sym_q == tok_in.sym)
				next = tok_in.diag;
			else
				next = min_all + led_pkg::LEN_W'(1);
		end else begin
			next = dp_q;
		end

		tok_d      = tok_in;
		tok_d.left = next;
		tok_d.diag = dp_q;
		if (tok_in.fin) begin
			// closing token: the cell that sees a count of one sits at the end of the first word
			if (tok_in.cnt == led_pkg::LEN_W'(1) && !tok_in.done) begin
				tok_d.done      = 1'b1;
				tok_d.edit_dist = next;
			end
			if (tok_in.cnt != '0)
				tok_d.cnt = tok_in.cnt - led_pkg::LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q  <= pos;
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (tok_in.valid) begin
				// the closing word restores row zero behind itself
				dp_q <= tok_in.fin ? pos : next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.pos == pos)
			sym_q <= wr.sym;
	end

	assign tok_out = tok_q;

endmodule

// ===== hdl/led_ctrl.sv =====
// input handling: word lengths, symbol writes and wavefront launch
module led_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	led_in_if.sink        item,
	input  logic          out_free,
	output led_pkg::tok_t tok,
	output led_pkg::wr_t  wr
);

	logic [led_pkg::LEN_W-1:0] first_len_q;
	logic [led_pkg::LEN_W-1:0] second_len_q;
	logic                      loading_q;
	logic                      ovf_q;
	logic [led_pkg::LEN_W-1:0] drain_q;
	led_pkg::tok_t             tok_d;
	led_pkg::tok_t             tok_q;
	logic                      final_item;
	logic                      acc;
	logic                      first_room;
	logic                      second_room;
	logic                      compute;
	logic [led_pkg::LEN_W-1:0] second_next;

	assign final_item  = item.data.command && item.data.last && loading_q;
	assign item.ready  = (drain_q == '0) && (!final_item || out_free);
	assign acc         = item.valid && item.ready;
	assign first_room  = first_len_q < led_pkg::LEN_W'(led_pkg::MAX_LEN);
	assign second_room = second_len_q < led_pkg::LEN_W'(led_pkg::MAX_LEN);
	assign compute     = item.data.has_symbol && second_room;
	assign second_next = compute ? second_len_q + led_pkg::LEN_W'(1) : second_len_q;

	always_comb begin
		wr.en  = acc && !item.data.command && !loading_q && item.data.has_symbol && first_room;
		wr.pos = first_len_q + led_pkg::LEN_W'(1);
		wr.sym = item.data.symbol[led_pkg::SYMBOL_BITS-1:0];
	end

	always_comb begin
		tok_d           = '0;
		tok_d.compute   = compute;
		tok_d.sym       = item.data.symbol[led_pkg::SYMBOL_BITS-1:0];
		tok_d.left      = second_len_q + led_pkg::LEN_W'(1);
		tok_d.diag      = second_len_q;
		tok_d.fin       = item.data.last;
		tok_d.cnt       = first_len_q;
		// empty first word: the distance is the second word's length
		tok_d.done      = first_len_q == '0;
		tok_d.edit_dist = second_next;
		tok_d.ovf       = ovf_q || (item.data.has_symbol && !second_room);
		tok_d.valid     = acc && item.data.command && loading_q && (compute || item.data.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			loading_q    <= 1'b0;
			ovf_q        <= 1'b0;
			drain_q      <= '0;
			tok_q        <= '0;
		end else begin
			tok_q <= tok_d;
			if (drain_q != '0)
				drain_q <= drain_q - led_pkg::LEN_W'(1);
			if (acc) begin
				if (!item.data.command) begin
					if (!loading_q) begin
						if (item.data.has_symbol) begin
							if (first_room)
								first_len_q <= first_len_q + led_pkg::LEN_W'(1);
							else
								ovf_q <= 1'b1;
						end
						if (item.data.last)
							loading_q <= 1'b1;
					end
				end else if (loading_q) begin
					if (item.data.last) begin
						first_len_q  <= '0;
						second_len_q <= '0;
						loading_q    <= 1'b0;
						ovf_q        <= 1'b0;
						drain_q      <= led_pkg::LEN_W'(led_pkg::MAX_LEN);
					end else begin
						second_len_q <= second_next;
						if (item.data.has_symbol && !second_room)
							ovf_q <= 1'b1;
					end
				end
			end
		end
	end

	assign tok = tok_q;

	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q != '0 |-> !item.ready)
		else $error("word taken while the chain drains");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && final_item |=> drain_q == led_pkg::LEN_W'(led_pkg::MAX_LEN))
		else $error("drain not started after closing word");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_len_q <= led_pkg::LEN_W'(led_pkg::MAX_LEN) &&
		second_len_q <= led_pkg::LEN_W'(led_pkg::MAX_LEN))
		else $error("word length beyond limit");

endmodule

// ===== hdl/levenshtein_edit_distance_top.sv =====
// levenshtein edit distance: controller, chain of cells and result register
//
// item channel (valid/ready, sink): each word carries command, has_symbol,
// symbol and last. first-word words (command 0) store one symbol each in the
// next cell of the chain; second-word words (command 1) launch a token that
// walks the chain one cell per cycle and updates the dp row behind it.
// second-word symbols are taken back to back, one per cycle.
// the second word's last word launches a closing token; the result word
// (distance, overflow) appears on the result channel once that token has passed
// the controller's token register, each of the MAX_LEN cells and the output
// register. while that token drains the item channel is not ready, and the
// closing token restores row zero in each cell.
// symbols past MAX_LEN are dropped and flag overflow.
// a finished result waits in the output register while the receiver stalls;
// words keep being taken, except a closing word, which waits for a free slot.
// reset (arst_n low) empties both words, sets row zero and drops any result.
module levenshtein_edit_distance_top (
	input  logic      clk,
	input  logic      arst_n,
	led_in_if.sink    item,
	led_out_if.source result
);

	led_pkg::tok_t chain [led_pkg::MAX_LEN+1];
	led_pkg::wr_t  wr;
	led_pkg::tok_t end_tok;
	logic          out_valid_q;
	logic          out_free;
	led_pkg::out_word_t out_q;

	assign out_free = !out_valid_q || result.ready;

	led_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.out_free (out_free),
		.tok      (chain[0]),
		.wr       (wr)
	);

	for (genvar g = 0; g < led_pkg::MAX_LEN; g++) begin : g_cell
		led_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.pos     (led_pkg::LEN_W'(g + 1)),
			.wr      (wr),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	assign end_tok = chain[led_pkg::MAX_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_tok.valid && end_tok.fin) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_tok.valid && end_tok.fin) begin
			out_q.distance <= led_pkg::DIST_W'(end_tok.edit_dist);
			out_q.overflow <= end_tok.ovf;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		end_tok.valid && end_tok.fin |-> out_free)
		else $error("result overwritten while waiting");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(end_tok.valid && end_tok.fin))
		else $error("result without closing token");

	a_closing_done: assert property (@(posedge clk) disable iff (!arst_n)
		end_tok.valid && end_tok.fin |-> end_tok.done)
		else $error("closing token left the chain without a distance");

endmodule

// ===== dv/led_distance_check.sv =====
// watches both channels, predicts each edit distance and compares it with the result word
`timescale 1ns / 100ps

module led_distance_check (
	input  logic clk,
	input  logic arst_n,
	led_in_if    item,
	led_out_if   result,
	output int   fail_count,
	output int   pending,
	output int   checked_count,
	output int   overflow_count,
	output int   max_distance
);

	logic [led_pkg::SYMBOL_BITS-1:0] stored_syms [led_pkg::MAX_LEN];
	int                              first_len;
	int                              second_len;
	int                              dp_cost [led_pkg::MAX_LEN+1];
	bit                              second_phase;
	bit                              ovf_flag;
	led_pkg::out_word_t              expected_distances [$];

	task automatic clear_pair();
		for (int i = 0; i <= led_pkg::MAX_LEN; i++) begin
			dp_cost[i] = i;
		end
		first_len    = 0;
		second_len   = 0;
		second_phase = 1'b0;
		ovf_flag     = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		led_pkg::in_word_t               w;
		led_pkg::out_word_t              got;
		led_pkg::out_word_t              want;
		logic [led_pkg::SYMBOL_BITS-1:0] sym;
		int                              diag;
		int                              up;
		int                              lft;
		int                              nxt;
		if (!arst_n) begin
			clear_pair();
			expected_distances.delete();
			fail_count     = 0;
			pending        = 0;
			checked_count  = 0;
			overflow_count = 0;
			max_distance   = 0;
		end else begin
			// result side first: a word taken this edge cannot be answered this edge
			if (result.valid && result.ready) begin
				got = result.data;
				if (expected_distances.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result word with nothing expected: distance %0d overflow %0b",
							$realtime, got.distance, got.overflow);
					fail_count++;
				end else begin
					want = expected_distances.pop_front();
					checked_count++;
					if (want.overflow)
						overflow_count++;
					if (int'(want.distance) > max_distance)
						max_distance = int'(want.distance);
					if (got.distance !== want.distance || got.overflow !== want.overflow) begin
						if (fail_count < 10)
							$display("%0t: expected distance %0d overflow %0b, got distance %0d overflow %0b",
								$realtime, want.distance, want.overflow, got.distance, got.overflow);
						fail_count++;
					end
				end
			end

			if (item.valid && item.ready) begin
				w   = item.data;
				sym = w.symbol[led_pkg::SYMBOL_BITS-1:0];
				if (!w.command) begin
					// first-word words are ignored once the second word has begun
					if (!second_phase) begin
						if (w.has_symbol) begin
							if (first_len < led_pkg::MAX_LEN) begin
								stored_syms[first_len] = sym;
								first_len++;
							end else begin
								ovf_flag = 1'b1;
							end
						end
						if (w.last)
							second_phase = 1'b1;
					end
				end else if (second_phase) begin
					if (w.has_symbol) begin
						if (second_len < led_pkg::MAX_LEN) begin
							// one more row of the table
							diag       = dp_cost[0];
							dp_cost[0] = second_len + 1;
							for (int i = 1; i <= first_len; i++) begin
								up  = dp_cost[i];
								lft = dp_cost[i-1];
								if (stored_syms[i-1] == sym) begin
									nxt = diag;
								end else begin
									nxt = (up < lft) ? up : lft;
									nxt = 1 + ((nxt < diag) ? nxt : diag);
								end
								diag       = up;
								dp_cost[i] = nxt;
							end
							second_len++;
						end else begin
							ovf_flag = 1'b1;
						end
					end
					if (w.last) begin
						want.distance = led_pkg::DIST_W'(dp_cost[first_len]);
						want.overflow = ovf_flag;
						expected_distances.insert(expected_distances.size(), want);
						clear_pair();
					end
				end
			end
			pending = expected_distances.size();
		end
	end

endmodule

// ===== dv/levenshtein_edit_distance_top_test.sv =====
// stimulus, handshake timing and verdict for the levenshtein edit distance block
`timescale 1ns / 100ps

module levenshtein_edit_distance_top_test;

	localparam logic CMD_FIRST   = 1'b0;
	localparam logic CMD_SECOND  = 1'b1;
	localparam int   WORD_TARGET = 1000;
	localparam int   CYCLE_LIMIT = 300000;

	typedef logic [7:0] sym_q_t [$];
	typedef enum {EDIT_INSERT, EDIT_DELETE, EDIT_SUBST} edit_op_t;

	logic clk;
	logic arst_n;

	led_in_if  item_ch ();
	led_out_if result_ch ();

	int fail_count;
	int pending;
	int checked_count;
	int overflow_count;
	int max_distance;

	int     counted_words;
	int     total_words;
	int     cycle_count;
	bit     no_gaps;
	bit     full_alphabet;
	sym_q_t first_syms;
	sym_q_t second_syms;

	levenshtein_edit_distance_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	led_distance_check scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item_ch),
		.result         (result_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked_count  (checked_count),
		.overflow_count (overflow_count),
		.max_distance   (max_distance)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles with %0d distances outstanding",
				cycle_count, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] pick_sym();
		if (full_alphabet)
			return 8'($urandom_range(0, 255));
		return 8'h61 + 8'($urandom_range(0, 3));
	endfunction

	// mostly short words, some up to the limit, a few past it
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 15);
		if (r < 12)
			return $urandom_range(0, 10);
		if (r < 15)
			return $urandom_range(11, led_pkg::MAX_LEN);
		return $urandom_range(led_pkg::MAX_LEN + 1, led_pkg::MAX_LEN + 8);
	endfunction

	// called just after a rising edge; returns just after the edge that took the word
	task automatic send_word(input logic cmd, input logic has, input logic [7:0] sym,
		input logic lst, input bit counts);
		int                gap;
		bit                got;
		led_pkg::in_word_t w;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.command    = cmd;
		w.has_symbol = has;
		w.symbol     = sym;
		w.last       = lst;
		item_ch.data  <= w;
		item_ch.valid <= 1'b1;
		do begin
			@(negedge clk);
			got = item_ch.ready;
			@(posedge clk);
		end while (!got);
		total_words++;
		if (counts)
			counted_words++;
	endtask

	task automatic send_symbols(input logic cmd, input sym_q_t syms);
		bit marker_end;
		marker_end = (syms.size() == 0) || ($urandom_range(0, 3) == 0);
		foreach (syms[i]) begin
			// empty word with no end: changes nothing
			if ($urandom_range(0, 9) == 0)
				send_word(cmd, 1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_word(cmd, 1'b1, syms[i], (i == syms.size() - 1) && !marker_end, 1'b1);
		end
		if (marker_end)
			send_word(cmd, 1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endtask

	task automatic run_pair();
		// a second-word word before the first word ends is dropped
		if ($urandom_range(0, 7) == 0)
			send_word(CMD_SECOND, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'b0);
		send_symbols(CMD_FIRST, first_syms);
		// and a first-word word while the second word loads
		if ($urandom_range(0, 7) == 0)
			send_word(CMD_FIRST, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'b0);
		send_symbols(CMD_SECOND, second_syms);
	endtask

	task automatic wait_for_drain();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// result side: either ready ahead of time or held off for a while once a word shows
	initial begin : result_sink
		int stall;
		bit got;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (stall == 0) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b0;
				do @(negedge clk); while (!result_ch.valid);
				@(posedge clk);
				repeat (stall - 1) @(posedge clk);
				result_ch.ready <= 1'b1;
			end
			do begin
				@(negedge clk);
				got = result_ch.valid;
				@(posedge clk);
			end while (!got);
		end
	end

	initial begin : stimulus
		int       n;
		int       pos;
		edit_op_t op;
		arst_n        <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		no_gaps       = 1'b0;
		full_alphabet = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty words, stray words, extreme symbol codes
		send_word(CMD_SECOND, 1'b1, 8'h61, 1'b1, 1'b0);
		send_word(CMD_FIRST, 1'b0, 8'h00, 1'b1, 1'b1);
		send_word(CMD_SECOND, 1'b0, 8'h00, 1'b1, 1'b1);
		send_word(CMD_FIRST, 1'b0, 8'h00, 1'b1, 1'b1);
		send_word(CMD_SECOND, 1'b1, 8'h61, 1'b0, 1'b1);
		send_word(CMD_SECOND, 1'b0, 8'hff, 1'b0, 1'b0);
		send_word(CMD_SECOND, 1'b1, 8'h62, 1'b1, 1'b1);
		send_word(CMD_FIRST, 1'b1, 8'h00, 1'b0, 1'b1);
		send_word(CMD_FIRST, 1'b1, 8'hff, 1'b1, 1'b1);
		send_word(CMD_FIRST, 1'b1, 8'h7a, 1'b1, 1'b0);
		send_word(CMD_SECOND, 1'b0, 8'h00, 1'b1, 1'b1);
		send_word(CMD_FIRST, 1'b1, 8'h00, 1'b0, 1'b1);
		send_word(CMD_FIRST, 1'b0, 8'h00, 1'b0, 1'b0);
		send_word(CMD_FIRST, 1'b1, 8'hff, 1'b1, 1'b1);
		send_word(CMD_SECOND, 1'b1, 8'hff, 1'b0, 1'b1);
		send_word(CMD_SECOND, 1'b1, 8'h00, 1'b1, 1'b1);
		send_word(CMD_FIRST, 1'b1, 8'ha5, 1'b1, 1'b1);
		send_word(CMD_SECOND, 1'b1, 8'ha5, 1'b1, 1'b1);
		send_word(CMD_FIRST, 1'b1, 8'h5a, 1'b0, 1'b1);
		send_word(CMD_FIRST, 1'b1, 8'ha5, 1'b1, 1'b1);
		send_word(CMD_SECOND, 1'b1, 8'ha5, 1'b1, 1'b1);
		wait_for_drain();

		// full-length words with no symbol in common: largest distance
		first_syms.delete();
		second_syms.delete();
		repeat (led_pkg::MAX_LEN) first_syms.insert(first_syms.size(), pick_sym());
		repeat (led_pkg::MAX_LEN)
			second_syms.insert(second_syms.size(), 8'h77 + 8'($urandom_range(0, 3)));
		run_pair();

		// both words too long
		full_alphabet = 1'b1;
		first_syms.delete();
		second_syms.delete();
		repeat (led_pkg::MAX_LEN + 4) first_syms.insert(first_syms.size(), pick_sym());
		repeat (led_pkg::MAX_LEN + 2) second_syms.insert(second_syms.size(), pick_sym());
		run_pair();

		while (counted_words < WORD_TARGET) begin
			no_gaps       = ($urandom_range(0, 4) == 0);
			full_alphabet = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// noise: any field, any order
				repeat ($urandom_range(3, 12))
					send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			end else begin
				first_syms.delete();
				n = pick_len();
				repeat (n) first_syms.insert(first_syms.size(), pick_sym());
				if ($urandom_range(0, 2) == 0) begin
					second_syms.delete();
					n = pick_len();
					repeat (n) second_syms.insert(second_syms.size(), pick_sym());
				end else begin
					// a few edits away from the first word
					second_syms = first_syms;
					repeat ($urandom_range(0, 3)) begin
						op = edit_op_t'($urandom_range(0, 2));
						if (op == EDIT_INSERT || second_syms.size() == 0) begin
							second_syms.insert($urandom_range(0, second_syms.size()), pick_sym());
						end else begin
							pos = $urandom_range(0, second_syms.size() - 1);
							if (op == EDIT_DELETE)
								second_syms.delete(pos);
							else
								second_syms[pos] = pick_sym();
						end
					end
				end
				run_pair();
			end
			if ($urandom_range(0, 7) == 0)
				wait_for_drain();
		end

		no_gaps = 1'b0;
		wait_for_drain();
		repeat (led_pkg::MAX_LEN + 8) @(posedge clk);
		@(negedge clk);
		$display("sent %0d words (%0d counted) incl. empty, stray, noise and too-long words",
			total_words, counted_words);
		$display("checked %0d distances, %0d with overflow, largest %0d",
			checked_count, overflow_count, max_distance);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
